>>> rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the contrast stretch channel block.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_GRAY_MODE = 3'd0;
    localparam logic [2:0] REG_CHANNEL   = 3'd1;
    localparam logic [2:0] REG_BLACK     = 3'd2;
    localparam logic [2:0] REG_WHITE     = 3'd3;
    localparam logic [2:0] REG_MAX       = 3'd4;

    localparam logic [1:0] CH_INVALID = 2'd0;
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_LAST   = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_in;
        logic                row_end;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                bad_channel;
    } t_out_word;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [SAMPLE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/csc_div.sv
// ----------------------------------------------------------------------------
// csc_div
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle. The caller guarantees the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module csc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csc_pkg::t_div_req i_req,
    output csc_pkg::t_div_rsp o_rsp
);
    import csc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_W);

    logic [SAMPLE_W-1:0] r_rem, n_rem;
    logic [SAMPLE_W-1:0] r_low, n_low;
    logic [SAMPLE_W-1:0] r_den, n_den;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;

    logic [SAMPLE_W:0] w_trial;
    logic [SAMPLE_W:0] w_diff;
    logic              w_ge;

    // shift the next dividend bit into the partial remainder and try the subtract
    assign w_trial = {r_rem, r_low[SAMPLE_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_low  = r_low;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.num[PROD_W-1:SAMPLE_W];
            n_low  = i_req.num[SAMPLE_W-1:0];
            n_den  = i_req.den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[SAMPLE_W-1:0] : w_trial[SAMPLE_W-1:0];
            n_low = {r_low[SAMPLE_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(SAMPLE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_low;

endmodule

>>> rtl/contrast_stretch_channel_top.sv
// ----------------------------------------------------------------------------
// contrast_stretch_channel_top
// Linear contrast stretch of a gray or interleaved RGB sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (sample, row end flag) arrive on i_in_valid / o_in_stall in
//   raster order; one result word per input leaves on o_out_valid /
//   i_out_stall. A word is taken when valid is high and stall is low. The
//   user writes registers over the APB port (gray mode, channel, black, white,
//   max level at byte addresses 0, 4, 8, 12, 16) only while idle; unchecked.
// Sequencing:
//   One word is worked on at a time. A sample that needs the divide goes
//   from acceptance to the next acceptance through a setup step, a
//   multiply step, 16 steps of the restoring divider plus its done
//   register, and a step to load the output register. A sample that is
//   passed, clamped to zero or clamped to max goes straight to that load.
// Reset:
//   Synchronous, active low. Registers return to gray mode, red channel,
//   black 1, white 255, max 255; the RGB position returns to row start.
// Stall:
//   A held result sits in the output register; the block takes the next
//   word meanwhile and holds its own result until the register frees.
// ----------------------------------------------------------------------------
module contrast_stretch_channel_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  csc_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output csc_pkg::t_out_word          o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csc_pkg::ADDR_W-1:0]  paddr,
    input  logic [csc_pkg::DATA_W-1:0]  pwdata,
    output logic [csc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import csc_pkg::*;

    localparam logic [SAMPLE_W-1:0] SampleMask =
        SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // configuration
    logic                r_gray;
    logic [1:0]          r_chan;
    logic [SAMPLE_W-1:0] r_black;
    logic [SAMPLE_W-1:0] r_white;
    logic [SAMPLE_W-1:0] r_max;

    logic       w_cfg_wr;
    logic [2:0] w_cfg_idx;

    // sequencer and datapath
    logic [1:0]          r_state, n_state;
    logic [1:0]          r_pos, n_pos;
    logic [SAMPLE_W-1:0] r_diff, n_diff;
    logic [SAMPLE_W-1:0] r_den, n_den;
    logic [SAMPLE_W-1:0] r_res, n_res;
    logic                r_bad, n_bad;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out_word, n_out_word;

    logic                w_accept;
    logic                w_out_free;
    logic [SAMPLE_W-1:0] w_s;
    logic [SAMPLE_W-1:0] w_mx;
    logic                w_sel;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray  <= 1'b1;
            r_chan  <= 2'd1;
            r_black <= SAMPLE_W'(1);
            r_white <= SAMPLE_W'(255);
            r_max   <= SAMPLE_W'(255);
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_GRAY_MODE: r_gray  <= pwdata[0];
                REG_CHANNEL:   r_chan  <= pwdata[1:0];
                REG_BLACK:     r_black <= pwdata[SAMPLE_W-1:0];
                REG_WHITE:     r_white <= pwdata[SAMPLE_W-1:0];
                REG_MAX:       r_max   <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_GRAY_MODE: prdata = DATA_W'(r_gray);
            REG_CHANNEL:   prdata = DATA_W'(r_chan);
            REG_BLACK:     prdata = DATA_W'(r_black);
            REG_WHITE:     prdata = DATA_W'(r_white);
            REG_MAX:       prdata = DATA_W'(r_max);
            default:       prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_s  = i_in_word.sample_in & SampleMask;
    assign w_mx = r_max & SampleMask;
    assign w_sel = r_gray || ((r_chan != CH_INVALID) && (r_pos == r_chan - 2'd1));

    // multiply feeds the divider's load registers directly
    assign w_div_req.start = (r_state == ST_MUL);
    assign w_div_req.num   = PROD_W'(r_diff) * PROD_W'(w_mx);
    assign w_div_req.den   = r_den;

    csc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_diff      = r_diff;
        n_den       = r_den;
        n_res       = r_res;
        n_bad       = r_bad;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_bad  = !r_gray && (r_chan == CH_INVALID);
                    n_diff = w_s - r_black;
                    n_den  = r_white - r_black;
                    n_pos  = (i_in_word.row_end || r_pos >= POS_LAST) ?
                             POS_FIRST : r_pos + 2'd1;
                    priority if (!w_sel) begin
                        n_res   = w_s;
                        n_state = ST_FIN;
                    end else if (w_s <= r_black) begin
                        n_res   = '0;
                        n_state = ST_FIN;
                    end else if (w_s < r_white) begin
                        n_state = ST_MUL;
                    end else begin
                        n_res   = w_mx;
                        n_state = ST_FIN;
                    end
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_res   = w_div_rsp.quot;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register frees
                if (w_out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_word.sample_out  = r_res;
                    n_out_word.bad_channel = r_bad;
                    n_state                = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= POS_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff     <= n_diff;
        r_den      <= n_den;
        r_res      <= n_res;
        r_bad      <= n_bad;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> rtl/csc_checker.sv
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks for the contrast stretch channel block, bound to the top.
// ----------------------------------------------------------------------------
module csc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  csc_pkg::t_out_word o_out_word
);

    // one word in flight: an accepted word blocks the input next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a word was accepted");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result changed or dropped");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // reset leaves the input open
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind contrast_stretch_channel_top csc_checker u_csc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
